// ===== hdl/crc_remainder_checker_top_macros.svh =====
// assertion macros used by the division module of the crc remainder checker
`ifndef CRC_REMAINDER_CHECKER_TOP_MACROS_SVH
`define CRC_REMAINDER_CHECKER_TOP_MACROS_SVH

// same-cycle implication
`define RCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rcc_pkg.sv =====
// types and constants of the crc remainder checker
package rcc_pkg;

    localparam int DEF_MAX_DEGREE = 32;
    localparam int DEGREE_W       = 6;
    localparam int TAPS_W         = 32;
    localparam int CFG_DATA_W     = 32;
    localparam int TDATA_W        = 8;

    localparam logic [DEGREE_W-1:0] RESET_DEGREE = 6'd16;
    localparam logic [TAPS_W-1:0]   RESET_TAPS   = 32'h0000_1021;

    typedef enum logic [0:0] {
        REG_DEGREE = 1'b0,
        REG_TAPS   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic frame_end;
        logic data_bit;
    } t_bit_word;

endpackage

// ===== hdl/rcc_cfg.sv =====
// generator registers and derived division mask and taps
module rcc_cfg
    import rcc_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_reg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [MAX_DEGREE-1:0] o_mask,
    output logic [MAX_DEGREE-1:0] o_taps,
    output logic [IDX_W-1:0]      o_top_idx
);

    logic [DEGREE_W-1:0] r_degree, n_degree;
    logic [TAPS_W-1:0]   r_taps, n_taps;
    logic [DEGREE_W:0]   active_n;
    logic [63:0]         taps_wide;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_degree = r_degree;
        n_taps   = r_taps;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEGREE: n_degree = i_cfg_data[DEGREE_W-1:0];
                REG_TAPS:   n_taps   = i_cfg_data[TAPS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= RESET_DEGREE;
            r_taps   <= RESET_TAPS;
        end else begin
            r_degree <= n_degree;
            r_taps   <= n_taps;
        end
    end

    // degree clamped to 1..MAX_DEGREE
    always_comb begin
        if (r_degree == '0) begin
            active_n = (DEGREE_W+1)'(1);
        end else if ({1'b0, r_degree} > (DEGREE_W+1)'(MAX_DEGREE)) begin
            active_n = (DEGREE_W+1)'(MAX_DEGREE);
        end else begin
            active_n = {1'b0, r_degree};
        end
    end

    assign taps_wide = {32'b0, r_taps};
    assign o_top_idx = IDX_W'(active_n - (DEGREE_W+1)'(1));

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            o_mask[i] = ((DEGREE_W+1)'(i) < active_n);
            o_taps[i] = taps_wide[i] & ((DEGREE_W+1)'(i) < active_n);
        end
    end

endmodule

// ===== hdl/rcc_in_reg.sv =====
// input register of the bit stream
module rcc_in_reg
    import rcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_bit_word i_word,
    output logic      o_valid,
    input  logic      i_take,
    output t_bit_word o_word
);

    logic      r_valid, n_valid;
    t_bit_word r_word;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hdl/rcc_div.sv =====
// serial mod-2 division step, remainder and result register
module rcc_div
    import rcc_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_bit_word             i_word,
    output logic                  o_take,
    input  logic [MAX_DEGREE-1:0] i_mask,
    input  logic [MAX_DEGREE-1:0] i_taps,
    input  logic [IDX_W-1:0]      i_top_idx,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_crc_error
);

`include "crc_remainder_checker_top_macros.svh"

    logic [MAX_DEGREE-1:0] r_rem, n_rem;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_err;
    logic [MAX_DEGREE-1:0] cur, shifted, step;
    logic                  top;

    assign o_take = i_valid && (!i_word.frame_end || !r_out_valid || i_ready);

    always_comb begin
        cur     = r_rem & i_mask;
        top     = cur[i_top_idx];
        shifted = ((cur << 1) | MAX_DEGREE'(i_word.data_bit)) & i_mask;
        step    = shifted ^ (top ? i_taps : '0);
    end

    always_comb begin
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_ready;
        if (o_take) begin
            n_rem = i_word.frame_end ? '0 : step;
            if (i_word.frame_end) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_word.frame_end) begin
            r_out_err <= (step != '0);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_error = r_out_err;

    `RCC_ASSERT_NEXT(a_clear_after_last, o_take && i_word.frame_end, r_rem == '0 && r_out_valid,
        "remainder not cleared or result missing after last bit")
    `RCC_ASSERT_NEXT(a_rem_in_mask, o_take, (r_rem & ~$past(i_mask)) == '0,
        "remainder has bits above the degree")
    `RCC_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_ready && i_valid && i_word.frame_end,
        !o_take, "pending result overwritten")

endmodule

// ===== hdl/crc_remainder_checker_top.sv =====
// crc remainder checker: serial crc check with configurable generator
// a codeword's last bit passes the input register, then the division result register
// throughput: one bit word per cycle, set by the single-step division register, except
// that a result waiting on the output holds a further last bit; other bits keep flowing
// reset (synchronous, active low) restores degree 16, taps 0x1021, zero remainder
// no clearing pass after reset; the block accepts words on the next cycle
module crc_remainder_checker_top
    import rcc_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // [0] data_bit, [7:1] zero
    input  logic                  s_axis_tlast,   // frame_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // [0] crc_error, [7:1] zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_reg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] taps;
    logic [IDX_W-1:0]      top_idx;
    t_bit_word             in_word;
    t_bit_word             held_word;
    logic                  held_valid;
    logic                  take;
    logic                  crc_error;

    assign in_word.data_bit  = s_axis_tdata[0];
    assign in_word.frame_end = s_axis_tlast;

    rcc_cfg #(
        .MAX_DEGREE (MAX_DEGREE),
        .IDX_W      (IDX_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mask      (mask),
        .o_taps      (taps),
        .o_top_idx   (top_idx)
    );

    rcc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (in_word),
        .o_valid (held_valid),
        .i_take  (take),
        .o_word  (held_word)
    );

    rcc_div #(
        .MAX_DEGREE (MAX_DEGREE),
        .IDX_W      (IDX_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_word      (held_word),
        .o_take      (take),
        .i_mask      (mask),
        .i_taps      (taps),
        .i_top_idx   (top_idx),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_crc_error (crc_error)
    );

    assign m_axis_tdata = {{(TDATA_W-1){1'b0}}, crc_error};

endmodule
